/* rtl/core/bsup_pkg.sv */
// ----------------------------------------------------------------------------
// Battery supervisor package
// Shared types, state codes and register indexes of the battery supervisor.
// ----------------------------------------------------------------------------
`default_nettype none

package bsup_pkg;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SHORT_WAIT   = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MEDIUM_WAIT  = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_VOLT_MAX     = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_VOLT_MIN     = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TEMP_MAX     = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TEMP_MIN     = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LEAVE_ERROR  = 3'd6;

    localparam logic [2:0] ST_UNINIT         = 3'd0;
    localparam logic [2:0] ST_INITIALIZATION = 3'd1;
    localparam logic [2:0] ST_INITIALIZED    = 3'd2;
    localparam logic [2:0] ST_STANDBY        = 3'd3;
    localparam logic [2:0] ST_ERROR          = 3'd4;

    localparam logic [1:0] SUB_ENTRY                 = 2'd0;
    localparam logic [1:0] SUB_CHECK_FLAGS_INTERLOCK = 2'd1;
    localparam logic [1:0] SUB_INTERLOCK_CHECKED     = 2'd2;
    localparam logic [1:0] SUB_CHECK_FLAGS           = 2'd3;

    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_INIT  = 2'd1;
    localparam logic [1:0] PEND_ERROR = 2'd2;

    localparam logic [1:0] REQ_INIT  = 2'd0;
    localparam logic [1:0] REQ_ERROR = 2'd1;

    localparam logic FUNC_TICK    = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_PENDING = 2'd1;
    localparam logic [1:0] STATUS_ILLEGAL = 2'd2;
    localparam logic [1:0] STATUS_ALREADY = 2'd3;

    localparam logic [1:0] ILCK_NONE  = 2'd0;
    localparam logic [1:0] ILCK_CLOSE = 2'd1;
    localparam logic [1:0] ILCK_OPEN  = 2'd2;

    localparam logic [7:0] ILLEGAL_COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic               func;
        logic [1:0]         request;
        logic [15:0]        cell_mv_high;
        logic [15:0]        cell_mv_low;
        logic signed [15:0] cell_temp_high;
        logic signed [15:0] cell_temp_low;
        logic [7:0]         safety_flags;
        logic [12:0]        system_error_flags;
    } in_item_t;

    typedef struct packed {
        logic [1:0] request_status;
        logic [2:0] machine_state;
        logic [1:0] machine_substate;
        logic [1:0] interlock_command;
        logic       init_done;
        logic       volt_high_alarm;
        logic       volt_low_alarm;
        logic       over_temperature;
        logic       under_temperature;
        logic       safety_any;
        logic       error_any;
        logic [7:0] illegal_count;
    } out_item_t;

    typedef struct packed {
        logic [7:0]         short_wait;
        logic [7:0]         medium_wait;
        logic [15:0]        volt_max_limit;
        logic [15:0]        volt_min_limit;
        logic signed [15:0] temp_max_limit;
        logic signed [15:0] temp_min_limit;
        logic               leave_error_enable;
    } cfg_regs_t;

    typedef struct packed {
        logic [2:0] main_state;
        logic [1:0] sub_state;
        logic [7:0] wait_timer;
        logic [1:0] pending_request;
        logic       init_finished;
        logic [7:0] illegal_requests;
    } sup_state_t;

endpackage

`default_nettype wire

/* rtl/core/bsup_cfg.sv */
// ----------------------------------------------------------------------------
// Battery supervisor configuration registers
// Holds the wait times, limits and recovery enable written over the
// configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bsup_cfg
    import bsup_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire logic [CFG_INDEX_WIDTH-1:0] wr_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  wr_data,
    output cfg_regs_t                       regs
);

    cfg_regs_t regs_reg;
    cfg_regs_t regs_next;

    always_comb
    begin
        regs_next = regs_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_SHORT_WAIT:  regs_next.short_wait         = wr_data[7:0];
                CFG_MEDIUM_WAIT: regs_next.medium_wait        = wr_data[7:0];
                CFG_VOLT_MAX:    regs_next.volt_max_limit     = wr_data;
                CFG_VOLT_MIN:    regs_next.volt_min_limit     = wr_data;
                CFG_TEMP_MAX:    regs_next.temp_max_limit     = $signed(wr_data);
                CFG_TEMP_MIN:    regs_next.temp_min_limit     = $signed(wr_data);
                CFG_LEAVE_ERROR: regs_next.leave_error_enable = wr_data[0];
                default:         regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.short_wait         <= 8'd1;
            regs_reg.medium_wait        <= 8'd10;
            regs_reg.volt_max_limit     <= 16'd4200;
            regs_reg.volt_min_limit     <= 16'd2500;
            regs_reg.temp_max_limit     <= 16'sd55;
            regs_reg.temp_min_limit     <= -16'sd20;
            regs_reg.leave_error_enable <= 1'b0;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

`default_nettype wire

/* rtl/core/bsup_step.sv */
// ----------------------------------------------------------------------------
// Battery supervisor step logic
// Computes the next supervisor state and the result of one transaction from
// the current state, the configuration and the incoming item.
// ----------------------------------------------------------------------------
`default_nettype none

module bsup_step
    import bsup_pkg::*;
(
    input  wire sup_state_t cur,
    input  wire cfg_regs_t  cfg,
    input  wire in_item_t   item,
    output sup_state_t      nxt,
    output out_item_t       res
);

    logic [7:0] timer_dec;
    logic       flagged;
    logic       run;
    logic [1:0] status;
    logic [1:0] ilck;
    logic       ov;
    logic       uv;
    logic       ot;
    logic       ut;
    logic       s_any;
    logic       e_any;

    assign timer_dec = cur.wait_timer - 8'd1;

    always_comb
    begin
        nxt     = cur;
        status  = STATUS_OK;
        ilck    = ILCK_NONE;
        ov      = 1'b0;
        uv      = 1'b0;
        ot      = 1'b0;
        ut      = 1'b0;
        s_any   = 1'b0;
        e_any   = 1'b0;
        flagged = 1'b0;
        run     = 1'b0;

        if (item.func == FUNC_REQUEST)
        begin
            if (item.request == REQ_ERROR)
            begin
                nxt.pending_request = PEND_ERROR;
            end
            else if (cur.pending_request != PEND_NONE)
            begin
                status = STATUS_PENDING;
            end
            else if (item.request == REQ_INIT)
            begin
                if (cur.main_state == ST_UNINIT)
                begin
                    nxt.pending_request = PEND_INIT;
                end
                else
                begin
                    status = STATUS_ALREADY;
                end
            end
            else
            begin
                status = STATUS_ILLEGAL;
            end
        end
        else
        begin
            s_any   = |item.safety_flags;
            e_any   = |item.system_error_flags;
            flagged = s_any | e_any;
            if (cur.main_state != ST_UNINIT)
            begin
                ov = item.cell_mv_high > cfg.volt_max_limit;
                uv = item.cell_mv_low < cfg.volt_min_limit;
                ot = $signed(item.cell_temp_high) > $signed(cfg.temp_max_limit);
                ut = $signed(item.cell_temp_low) < $signed(cfg.temp_min_limit);
            end

            run = 1'b1;
            if (cur.wait_timer != 8'd0)
            begin
                nxt.wait_timer = timer_dec;
                run            = (timer_dec == 8'd0);
            end

            if (run)
            begin
                unique case (cur.main_state)
                    ST_UNINIT:
                    begin
                        nxt.pending_request = PEND_NONE;
                        if (cur.pending_request == PEND_INIT)
                        begin
                            nxt.wait_timer = cfg.short_wait;
                            nxt.main_state = ST_INITIALIZATION;
                            nxt.sub_state  = SUB_ENTRY;
                        end
                        else if (cur.pending_request != PEND_NONE &&
                                 cur.illegal_requests != ILLEGAL_COUNT_MAX)
                        begin
                            nxt.illegal_requests = cur.illegal_requests + 8'd1;
                        end
                    end
                    ST_INITIALIZATION:
                    begin
                        nxt.wait_timer = cfg.short_wait;
                        nxt.main_state = ST_INITIALIZED;
                        nxt.sub_state  = SUB_ENTRY;
                    end
                    ST_INITIALIZED:
                    begin
                        nxt.init_finished = 1'b1;
                        nxt.wait_timer    = cfg.short_wait;
                        nxt.main_state    = ST_STANDBY;
                        nxt.sub_state     = SUB_ENTRY;
                    end
                    ST_STANDBY:
                    begin
                        unique case (cur.sub_state)
                            SUB_ENTRY:
                            begin
                                ilck           = ILCK_CLOSE;
                                nxt.wait_timer = cfg.medium_wait;
                                nxt.sub_state  = SUB_CHECK_FLAGS_INTERLOCK;
                            end
                            SUB_CHECK_FLAGS_INTERLOCK:
                            begin
                                nxt.wait_timer = cfg.short_wait;
                                if (flagged)
                                begin
                                    nxt.main_state = ST_ERROR;
                                    nxt.sub_state  = SUB_ENTRY;
                                end
                                else
                                begin
                                    nxt.sub_state = SUB_INTERLOCK_CHECKED;
                                end
                            end
                            SUB_INTERLOCK_CHECKED:
                            begin
                                nxt.wait_timer = cfg.short_wait;
                                nxt.sub_state  = SUB_CHECK_FLAGS;
                            end
                            default:
                            begin
                                if (flagged)
                                begin
                                    nxt.wait_timer = cfg.short_wait;
                                    nxt.main_state = ST_ERROR;
                                    nxt.sub_state  = SUB_ENTRY;
                                end
                            end
                        endcase
                    end
                    ST_ERROR:
                    begin
                        if (cur.sub_state == SUB_ENTRY)
                        begin
                            ilck           = ILCK_OPEN;
                            nxt.wait_timer = cfg.medium_wait;
                            nxt.sub_state  = SUB_CHECK_FLAGS;
                        end
                        else if (cur.sub_state == SUB_CHECK_FLAGS &&
                                 !flagged && cfg.leave_error_enable)
                        begin
                            ilck           = ILCK_CLOSE;
                            nxt.wait_timer = cfg.medium_wait;
                            nxt.main_state = ST_STANDBY;
                            nxt.sub_state  = SUB_ENTRY;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        res.request_status    = status;
        res.machine_state     = nxt.main_state;
        res.machine_substate  = nxt.sub_state;
        res.interlock_command = ilck;
        res.init_done         = nxt.init_finished;
        res.volt_high_alarm   = ov;
        res.volt_low_alarm    = uv;
        res.over_temperature  = ot;
        res.under_temperature = ut;
        res.safety_any        = s_any;
        res.error_any         = e_any;
        res.illegal_count     = nxt.illegal_requests;
    end

endmodule

`default_nettype wire

/* rtl/core/battery_supervisor_fsm_unit.sv */
// ----------------------------------------------------------------------------
// Battery supervisor state machine
// Safety supervisor for a battery pack: checks state requests, flags limit
// violations on ticks and steps the init, standby and error sequence.
//
// Usage: every transaction on the input channel (in_valid, in_ready, in_data)
// is either a tick carrying measurements and flags or a state request. Each
// input transaction produces exactly one result transaction on the output
// channel (out_valid, out_ready, out_data), in order.
// The supervisor state is updated in the cycle an item is accepted and the
// result is held in an output register, so the result appears in the cycle
// after acceptance. One item is accepted per cycle while the output register
// is empty or being drained; the single output register is what bounds this.
// When the receiver stalls, the pending result is held and in_ready drops
// once that register is full, so no result is ever lost or repeated.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready and writes one register per transaction; indexes beyond the
// last register are ignored. Reset returns the machine to uninitialized,
// clears the timer, pending request and counters, and restores the default
// wait times and limits. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_supervisor_fsm_unit
    import bsup_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire in_item_t                   in_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output out_item_t                       out_data,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    cfg_regs_t  cfg;
    sup_state_t state_reg;
    sup_state_t state_next;
    out_item_t  res_next;
    out_item_t  res_reg;
    logic       valid_reg;
    logic       accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    bsup_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .regs     (cfg)
    );

    bsup_step u_step (
        .cur  (state_reg),
        .cfg  (cfg),
        .item (in_data),
        .nxt  (state_next),
        .res  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.main_state       <= ST_UNINIT;
            state_reg.sub_state        <= SUB_ENTRY;
            state_reg.wait_timer       <= 8'd0;
            state_reg.pending_request  <= PEND_NONE;
            state_reg.init_finished    <= 1'b0;
            state_reg.illegal_requests <= 8'd0;
            valid_reg                  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = res_reg;

    // A close command is issued only on the way into or inside standby.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && res_reg.interlock_command == ILCK_CLOSE)
            |-> res_reg.machine_state == ST_STANDBY)
        else $error("close command outside standby");

    // An open command is issued only when entering the error sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && res_reg.interlock_command == ILCK_OPEN)
            |-> (res_reg.machine_state == ST_ERROR &&
                 res_reg.machine_substate == SUB_CHECK_FLAGS))
        else $error("open command outside error entry");

    // Once initialization has finished it never clears.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.init_finished |=> state_reg.init_finished)
        else $error("init_finished cleared");

    // The illegal-request counter never decreases.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg.illegal_requests >= $past(state_reg.illegal_requests))
        else $error("illegal request counter decreased");

    // A rejected request result carries no voltage alarm, safety or error flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && res_reg.request_status != STATUS_OK)
            |-> !(res_reg.volt_high_alarm || res_reg.volt_low_alarm ||
                  res_reg.safety_any || res_reg.error_any))
        else $error("flags set on a request result");

endmodule

`default_nettype wire
